>>> design/sht_pkg.sv
// Package for the segment hotness tracker: sizes, codes and sequencer states.
// Used by segment_hotness_tracker_top; no other dependencies.

package sht_pkg;

    localparam int TABLE_ENTRIES     = 64;
    localparam int NODES_PER_SEGMENT = 8;
    localparam int IDX_W             = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W            = (NODES_PER_SEGMENT > 1) ? $clog2(NODES_PER_SEGMENT) : 1;
    localparam int CNT_W             = $clog2(NODES_PER_SEGMENT + 1);
    localparam int HEAT_W            = 20;
    localparam int DIV_STEPS         = 16;

    localparam logic [HEAT_W-1:0] HEAT_MAX = {HEAT_W{1'b1}};

    localparam logic [1:0] CMD_TOUCH  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_DROP   = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TABLE_FULL = 2'd1;
    localparam logic [1:0] ST_SET_FULL   = 2'd2;

    localparam logic [1:0] CLS_COLD    = 2'd0;
    localparam logic [1:0] CLS_HOT     = 2'd1;
    localparam logic [1:0] CLS_HOTTEST = 2'd2;

    localparam logic [2:0] REG_WINDOW     = 3'd0;
    localparam logic [2:0] REG_INCREMENT  = 3'd1;
    localparam logic [2:0] REG_HOT        = 3'd2;
    localparam logic [2:0] REG_HOTTEST    = 3'd3;
    localparam logic [2:0] REG_REP_COLD   = 3'd4;
    localparam logic [2:0] REG_REP_HOT    = 3'd5;
    localparam logic [2:0] REG_REP_HOTTEST = 3'd6;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_ALLOC,
        S_FETCH,
        S_LOADED,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_ADDS,
        S_TCLS,
        S_LRD,
        S_LOUT,
        S_ARD,
        S_ACMP,
        S_ADEC,
        S_SHRD,
        S_SHWR,
        S_RRD,
        S_RCMP,
        S_RSHRD,
        S_RSHWR,
        S_EMIT
    } state_t;

endpackage

>>> design/segment_hotness_tracker_top.sv
// Segment hotness tracker: key table, decay arithmetic and per-segment node sets.
// Depends on sht_pkg.
//
// Channel   Dir  Signals                               Word
// s_*       in   s_tvalid s_tready s_tdata s_tuser     one command
// m_*       out  m_tvalid m_tready m_tdata m_tuser m_tlast  one result
// cfg_*     in   cfg_valid cfg_ready cfg_index cfg_data     one register write
//
// One command at a time. The key search reads the table entries in turn, each through
// S_SCAN_RD and S_SCAN_CMP; a touch may add the serial divider (S_DIV), the multiply
// states S_MUL1 and S_MUL2, and an S_LRD/S_LOUT pair per streamed node. Set edits
// read and write the slots visited in turn. Reset clears the used bits only; no clearing pass.
// A stalled result holds in the output register; s_tready is high only when idle.

module segment_hotness_tracker_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // segment_id[63:0], node_id[95:64], now_seconds[127:96]
    input  logic [1:0]   s_tuser,   // command[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // status[1:0], hotness_class[3:2], hotness_level[23:4],
                                    // copies_needed[27:24], cached_node[59:28], zero[63:60]
    output logic [0:0]   m_tuser,   // node_present[0]
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int IW = sht_pkg::IDX_W;
    localparam int SW = sht_pkg::SLOT_W;
    localparam int CW = sht_pkg::CNT_W;
    localparam int HW = sht_pkg::HEAT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(sht_pkg::TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] NODES_MAX = CW'(sht_pkg::NODES_PER_SEGMENT);

    // configuration
    logic [31:0] win_reg;
    logic [HW-1:0] inc_reg, hot_reg, hottest_reg;
    logic [3:0] rep_cold_reg, rep_hot_reg, rep_hottest_reg;

    // memories
    logic [63:0]   key_mem  [sht_pkg::TABLE_ENTRIES];
    logic [31:0]   time_mem [sht_pkg::TABLE_ENTRIES];
    logic [HW-1:0] heat_mem [sht_pkg::TABLE_ENTRIES];
    logic [CW-1:0] cnt_mem  [sht_pkg::TABLE_ENTRIES];
    logic [31:0]   node_mem [sht_pkg::TABLE_ENTRIES * sht_pkg::NODES_PER_SEGMENT];
    logic [63:0]   key_rd;
    logic [31:0]   time_rd, nd_rd;
    logic [HW-1:0] heat_rd;
    logic [CW-1:0] cnt_rd;

    logic [sht_pkg::TABLE_ENTRIES-1:0] used_reg, used_next;

    sht_pkg::state_t state_reg, state_next;

    logic [1:0]    cmd_reg, cmd_next;
    logic [63:0]   key_reg, key_next;
    logic [31:0]   node_reg, node_next;
    logic [31:0]   now_reg, now_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] ent_reg, ent_next;
    logic [HW-1:0] heat_reg, heat_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0]   rem_reg, rem_next;
    logic [16:0]   q_reg, q_next;
    logic [3:0]    step_reg, step_next;
    logic [51:0]   prod_reg, prod_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [1:0]    st_reg, st_next;
    logic [1:0]    cls_reg, cls_next;
    logic [HW-1:0] lvl_reg, lvl_next;
    logic [3:0]    cp_reg, cp_next;

    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;
    logic        m_pres_reg, m_pres_next;
    logic        m_last_reg, m_last_next;

    // memory access controls
    logic          ent_we, heat_we, cnt_we, node_we;
    logic [31:0]   time_wd;
    logic [HW-1:0] heat_wd;
    logic [CW-1:0] cnt_wd;
    logic [CW-1:0] rd_slot, wr_slot;
    logic [31:0]   node_wd;

    logic          in_fire, out_free, out_load;
    logic [31:0]   win_eff, elapsed;
    logic [32:0]   rem_sh;
    logic          free_now;
    logic [IW-1:0] free_pick;
    logic [32:0]   frac;
    logic [HW:0]   sum;
    logic [3:0]    want;
    logic [3:0]    cnt4;

    assign s_tready  = (state_reg == sht_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_pres_reg;
    assign m_tlast   = m_last_reg;

    assign win_eff   = (win_reg == 32'd0) ? 32'd1 : win_reg;
    assign elapsed   = now_reg - time_rd;
    assign rem_sh    = {rem_reg, 1'b0};
    assign free_now  = free_reg || !used_reg[idx_reg];
    assign free_pick = free_reg ? free_idx_reg : idx_reg;
    assign frac      = 33'h1_0000_0000 - prod_reg[32:0];
    assign sum       = {1'b0, prod_reg[51:32]} + {1'b0, inc_reg};
    assign cnt4      = 4'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg         <= 32'd43200;
            inc_reg         <= HW'(2560);
            hot_reg         <= HW'(3840);
            hottest_reg     <= HW'(6400);
            rep_cold_reg    <= 4'd0;
            rep_hot_reg     <= 4'd1;
            rep_hottest_reg <= 4'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sht_pkg::REG_WINDOW:      win_reg         <= cfg_data;
                sht_pkg::REG_INCREMENT:   inc_reg         <= cfg_data[HW-1:0];
                sht_pkg::REG_HOT:         hot_reg         <= cfg_data[HW-1:0];
                sht_pkg::REG_HOTTEST:     hottest_reg     <= cfg_data[HW-1:0];
                sht_pkg::REG_REP_COLD:    rep_cold_reg    <= cfg_data[3:0];
                sht_pkg::REG_REP_HOT:     rep_hot_reg     <= cfg_data[3:0];
                sht_pkg::REG_REP_HOTTEST: rep_hottest_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // memories: registered reads, one write port each
    always_ff @(posedge clk)
    begin
        key_rd  <= key_mem[idx_reg];
        time_rd <= time_mem[ent_reg];
        heat_rd <= heat_mem[ent_reg];
        cnt_rd  <= cnt_mem[ent_reg];
        nd_rd   <= node_mem[{ent_reg, rd_slot[SW-1:0]}];
        if (ent_we)
        begin
            key_mem[ent_reg] <= key_reg;
        end
        if (heat_we)
        begin
            heat_mem[ent_reg] <= heat_wd;
            time_mem[ent_reg] <= time_wd;
        end
        if (cnt_we)
        begin
            cnt_mem[ent_reg] <= cnt_wd;
        end
        if (node_we)
        begin
            node_mem[{ent_reg, wr_slot[SW-1:0]}] <= node_wd;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sht_pkg::S_IDLE:     if (in_fire) state_next = sht_pkg::S_SCAN_RD;
            sht_pkg::S_SCAN_RD:  state_next = sht_pkg::S_SCAN_CMP;
            sht_pkg::S_SCAN_CMP:
            begin
                if (used_reg[idx_reg] && key_rd == key_reg)
                    state_next = sht_pkg::S_FETCH;
                else if (idx_reg != LAST_IDX)
                    state_next = sht_pkg::S_SCAN_RD;
                else if ((cmd_reg == sht_pkg::CMD_TOUCH || cmd_reg == sht_pkg::CMD_ADD)
                         && free_now)
                    state_next = sht_pkg::S_ALLOC;
                else
                    state_next = sht_pkg::S_EMIT;
            end
            sht_pkg::S_ALLOC:    state_next = sht_pkg::S_FETCH;
            sht_pkg::S_FETCH:    state_next = sht_pkg::S_LOADED;
            sht_pkg::S_LOADED:
            begin
                case (cmd_reg)
                    sht_pkg::CMD_TOUCH:
                    begin
                        if (elapsed > win_eff)      state_next = sht_pkg::S_TCLS;
                        else if (elapsed == win_eff) state_next = sht_pkg::S_MUL1;
                        else                         state_next = sht_pkg::S_DIV;
                    end
                    sht_pkg::CMD_ADD:    state_next = sht_pkg::S_ARD;
                    sht_pkg::CMD_REMOVE: state_next = sht_pkg::S_RRD;
                    default:             state_next = sht_pkg::S_EMIT;
                endcase
            end
            sht_pkg::S_DIV:
                if (step_reg == 4'(sht_pkg::DIV_STEPS - 1)) state_next = sht_pkg::S_MUL1;
            sht_pkg::S_MUL1:     state_next = sht_pkg::S_MUL2;
            sht_pkg::S_MUL2:     state_next = sht_pkg::S_ADDS;
            sht_pkg::S_ADDS:     state_next = sht_pkg::S_TCLS;
            sht_pkg::S_TCLS:
                state_next = (cnt_reg == '0) ? sht_pkg::S_EMIT : sht_pkg::S_LRD;
            sht_pkg::S_LRD:      state_next = sht_pkg::S_LOUT;
            sht_pkg::S_LOUT:
                if (out_free)
                    state_next = (k_reg + 1'b1 == cnt_reg) ? sht_pkg::S_IDLE : sht_pkg::S_LRD;
            sht_pkg::S_ARD:
                state_next = (k_reg >= cnt_reg) ? sht_pkg::S_ADEC : sht_pkg::S_ACMP;
            sht_pkg::S_ACMP:
            begin
                if (nd_rd < node_reg)       state_next = sht_pkg::S_ARD;
                else if (nd_rd == node_reg) state_next = sht_pkg::S_EMIT;
                else                        state_next = sht_pkg::S_ADEC;
            end
            sht_pkg::S_ADEC:
                state_next = (cnt_reg >= NODES_MAX) ? sht_pkg::S_EMIT : sht_pkg::S_SHRD;
            sht_pkg::S_SHRD:
                state_next = (k_reg > pos_reg) ? sht_pkg::S_SHWR : sht_pkg::S_EMIT;
            sht_pkg::S_SHWR:     state_next = sht_pkg::S_SHRD;
            sht_pkg::S_RRD:
                state_next = (k_reg >= cnt_reg) ? sht_pkg::S_EMIT : sht_pkg::S_RCMP;
            sht_pkg::S_RCMP:
                state_next = (nd_rd == node_reg) ? sht_pkg::S_RSHRD : sht_pkg::S_RRD;
            sht_pkg::S_RSHRD:
                state_next = (k_reg + 1'b1 < cnt_reg) ? sht_pkg::S_RSHWR : sht_pkg::S_EMIT;
            sht_pkg::S_RSHWR:    state_next = sht_pkg::S_RSHRD;
            sht_pkg::S_EMIT:     if (out_free) state_next = sht_pkg::S_IDLE;
            default:             state_next = sht_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        used_next     = used_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        node_next     = node_reg;
        now_next      = now_reg;
        idx_next      = idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        ent_next      = ent_reg;
        heat_next     = heat_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        step_next     = step_reg;
        prod_next     = prod_reg;
        k_next        = k_reg;
        pos_next      = pos_reg;
        st_next       = st_reg;
        cls_next      = cls_reg;
        lvl_next      = lvl_reg;
        cp_next       = cp_reg;
        ent_we        = 1'b0;
        heat_we       = 1'b0;
        cnt_we        = 1'b0;
        node_we       = 1'b0;
        heat_wd       = lvl_reg;
        time_wd       = now_reg;
        cnt_wd        = '0;
        node_wd       = nd_rd;
        rd_slot       = k_reg;
        wr_slot       = k_reg;
        out_load      = 1'b0;
        want          = rep_cold_reg;
        case (state_reg)
            sht_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next  = s_tuser;
                    key_next  = s_tdata[63:0];
                    node_next = s_tdata[95:64];
                    now_next  = s_tdata[127:96];
                    idx_next  = '0;
                    free_next = 1'b0;
                    k_next    = '0;
                    st_next   = sht_pkg::ST_OK;
                    cls_next  = sht_pkg::CLS_COLD;
                    lvl_next  = '0;
                    cp_next   = '0;
                end
            end
            sht_pkg::S_SCAN_CMP:
            begin
                if (used_reg[idx_reg] && key_rd == key_reg)
                begin
                    ent_next = idx_reg;
                end
                else
                begin
                    if (!free_reg && !used_reg[idx_reg])
                    begin
                        free_next     = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        ent_next = free_pick;
                        if ((cmd_reg == sht_pkg::CMD_TOUCH || cmd_reg == sht_pkg::CMD_ADD)
                            && !free_now)
                            st_next = sht_pkg::ST_TABLE_FULL;
                    end
                end
            end
            sht_pkg::S_ALLOC:
            begin
                used_next[ent_reg] = 1'b1;
                ent_we  = 1'b1;
                heat_we = 1'b1;
                heat_wd = '0;
                time_wd = 32'd0;
                cnt_we  = 1'b1;
                cnt_wd  = '0;
            end
            sht_pkg::S_LOADED:
            begin
                heat_next = heat_rd;
                cnt_next  = cnt_rd;
                k_next    = '0;
                rem_next  = elapsed;
                step_next = '0;
                q_next    = (elapsed == win_eff) ? 17'h10000 : 17'd0;
                // only a touch reports a level; set edits keep it at zero
                if (cmd_reg == sht_pkg::CMD_TOUCH)
                    lvl_next = inc_reg;
                if (cmd_reg == sht_pkg::CMD_DROP)
                begin
                    cnt_we = 1'b1;
                    cnt_wd = '0;
                end
            end
            sht_pkg::S_DIV:
            begin
                // restoring division of elapsed*2^16 by the window, one bit per cycle
                if (rem_sh >= {1'b0, win_eff})
                begin
                    rem_next = 32'(rem_sh - {1'b0, win_eff});
                    q_next   = {q_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    q_next   = {q_reg[15:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
            end
            sht_pkg::S_MUL1:  prod_next = 52'(q_reg * q_reg);
            sht_pkg::S_MUL2:  prod_next = 52'(heat_reg * frac);
            sht_pkg::S_ADDS:  lvl_next = sum[HW] ? sht_pkg::HEAT_MAX : sum[HW-1:0];
            sht_pkg::S_TCLS:
            begin
                heat_we = 1'b1;
                if (lvl_reg > hottest_reg)
                begin
                    cls_next = sht_pkg::CLS_HOTTEST;
                    want     = rep_hottest_reg;
                end
                else if (lvl_reg > hot_reg)
                begin
                    cls_next = sht_pkg::CLS_HOT;
                    want     = rep_hot_reg;
                end
                else
                begin
                    cls_next = sht_pkg::CLS_COLD;
                    want     = rep_cold_reg;
                end
                cp_next = (want > cnt4) ? want - cnt4 : 4'd0;
            end
            sht_pkg::S_LOUT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    k_next   = k_reg + 1'b1;
                end
            end
            sht_pkg::S_ACMP:
            begin
                if (nd_rd < node_reg)
                    k_next = k_reg + 1'b1;
                else
                    pos_next = k_reg;
            end
            sht_pkg::S_ARD:
                if (k_reg >= cnt_reg) pos_next = k_reg;
            sht_pkg::S_ADEC:
            begin
                if (cnt_reg >= NODES_MAX)
                    st_next = sht_pkg::ST_SET_FULL;
                else
                    k_next = cnt_reg;
            end
            sht_pkg::S_SHRD:
            begin
                rd_slot = k_reg - 1'b1;
                if (k_reg <= pos_reg)
                begin
                    node_we = 1'b1;
                    wr_slot = pos_reg;
                    node_wd = node_reg;
                    cnt_we  = 1'b1;
                    cnt_wd  = cnt_reg + 1'b1;
                end
            end
            sht_pkg::S_SHWR:
            begin
                // move one slot up to open the insert position
                rd_slot = k_reg - 1'b1;
                node_we = 1'b1;
                k_next  = k_reg - 1'b1;
            end
            sht_pkg::S_RCMP:
                if (nd_rd != node_reg) k_next = k_reg + 1'b1;
            sht_pkg::S_RSHRD:
            begin
                rd_slot = k_reg + 1'b1;
                if (!(k_reg + 1'b1 < cnt_reg))
                begin
                    cnt_we = 1'b1;
                    cnt_wd = cnt_reg - 1'b1;
                end
            end
            sht_pkg::S_RSHWR:
            begin
                // close the gap left by the removed id
                rd_slot = k_reg + 1'b1;
                node_we = 1'b1;
                k_next  = k_reg + 1'b1;
            end
            sht_pkg::S_EMIT:  out_load = out_free;
            default: ;
        endcase
    end

    // output word
    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_pres_next  = m_pres_reg;
        m_last_next  = m_last_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            if (state_reg == sht_pkg::S_LOUT)
            begin
                m_data_next = {4'd0, nd_rd, cp_reg, lvl_reg, cls_reg, st_reg};
                m_pres_next = 1'b1;
                m_last_next = (k_reg + 1'b1 == cnt_reg);
            end
            else
            begin
                m_data_next = {4'd0, 32'd0, cp_reg, lvl_reg, cls_reg, st_reg};
                m_pres_next = 1'b0;
                m_last_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sht_pkg::S_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        node_reg     <= node_next;
        now_reg      <= now_next;
        idx_reg      <= idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        ent_reg      <= ent_next;
        heat_reg     <= heat_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        step_reg     <= step_next;
        prod_reg     <= prod_next;
        k_reg        <= k_next;
        pos_reg      <= pos_next;
        st_reg       <= st_next;
        cls_reg      <= cls_next;
        lvl_reg      <= lvl_next;
        cp_reg       <= cp_next;
        m_data_reg   <= m_data_next;
        m_pres_reg   <= m_pres_next;
        m_last_reg   <= m_last_next;
    end

endmodule
